// ===== hw/rtl/pwm_tone_sequencer_top_assert.svh =====
// ----------------------------------------------------------------------------
// pwm tone sequencer assertion macros
// shared property wrappers, sampled on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef PWM_TONE_SEQUENCER_TOP_ASSERT_SVH
`define PWM_TONE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define PST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pst check failed");

// next-cycle implication
`define PST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pst check failed");

`endif

// ===== hw/rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// shared widths, codes, reset values and control structs of the tone sequencer
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int TABLE_DEPTH_DEF = 32;

	localparam int FUNC_W     = 2;
	localparam int IDX_IN_W   = 5;
	localparam int FREQ_W     = 16;
	localparam int DUR_W      = 8;
	localparam int CLK_HZ_W   = 26;
	localparam int TPM_W      = 16;
	localparam int DUTY_W     = 7;
	localparam int PER_W      = 26;
	localparam int LEFT_W     = 24;
	localparam int POS_W      = 5;
	localparam int HI_Q_W     = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 26;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 8;

	// item kinds
	localparam logic [FUNC_W-1:0] FN_TICK  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_START = 2'd1;
	localparam logic [FUNC_W-1:0] FN_WRITE = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_PERCENT = 2'd2;

	localparam logic [CLK_HZ_W-1:0] CLOCK_HZ_RST = 26'd32000000;
	localparam logic [TPM_W-1:0]    TPM_RST      = 16'd32000;
	localparam logic [DUTY_W-1:0]   DUTY_RST     = 7'd50;
	localparam logic [DUTY_W-1:0]   DUTY_MAX     = 7'd100;
	localparam logic [FREQ_W-1:0]   PCT_DIVISOR  = 16'd100;

	// period / 100 as (period * ceil(2^33 / 100)) >> 33, exact for 26-bit periods
	localparam int                 RECIP_W     = 27;
	localparam int                 RECIP_SHIFT = 33;
	localparam logic [RECIP_W-1:0] RECIP_100   = 27'd85899346;

	typedef struct packed {
		logic tick;
		logic start;
		logic wr;
		logic rd;
		logic stop;
		logic div_per;
		logic per_zero;
		logic per_ld;
		logic div_hi;
		logic fin;
	} pst_cmd_t;

	typedef struct packed {
		logic playing;
		logic left_le1;
		logic oob;
		logic dur_zero;
		logic freq_zero;
		logic div_busy;
		logic div_done;
	} pst_sts_t;

endpackage

// ===== hw/rtl/pst_div.sv =====
// ----------------------------------------------------------------------------
// pst_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pst_div import pst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PER_W-1:0]  dividend,
	input  logic [FREQ_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [PER_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(PER_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(PER_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PER_W-1:0] quo_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] dsr_q;

	logic [FREQ_W:0]   shifted;
	logic [FREQ_W+1:0] diff;
	logic              q_bit;
	logic [FREQ_W-1:0] rem_nxt;

	assign shifted = {rem_q, quo_q[PER_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
	assign q_bit   = ~diff[FREQ_W+1];
	assign rem_nxt = q_bit ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PER_W-2:0], q_bit};
			rem_q <= rem_nxt;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/pst_dp.sv =====
// ----------------------------------------------------------------------------
// pst_dp
// datapath: config registers, note table, play state and note setup math
// ----------------------------------------------------------------------------
module pst_dp import pst_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  pst_cmd_t              cmd,
	input  logic [IDX_IN_W-1:0]   entry_index,
	input  logic [FREQ_W-1:0]     entry_freq_hz,
	input  logic [DUR_W-1:0]      entry_duration_ms,
	output pst_sts_t              sts,
	output logic                  tone_level,
	output logic                  busy_res,
	output logic [POS_W-1:0]      note_position
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int NEXT_W = IDX_W + 1;
	localparam int WR_W   = IDX_W + IDX_IN_W;
	localparam int MEM_W  = FREQ_W + DUR_W;
	localparam int HP_W   = HI_Q_W + DUTY_W;
	localparam int QP_W   = PER_W + RECIP_W;

	logic [CLK_HZ_W-1:0] clock_hz_q;
	logic [TPM_W-1:0]    tpm_q;
	logic [DUTY_W-1:0]   duty_q;

	logic [MEM_W-1:0] mem [TABLE_DEPTH];
	logic [MEM_W-1:0] rd_q;

	logic              playing_q;
	logic [LEFT_W-1:0] left_q;
	logic [PER_W-1:0]  period_q;
	logic [PER_W-1:0]  high_q;
	logic [PER_W-1:0]  phase_q;
	logic [IDX_W-1:0]  cur_q;
	logic [NEXT_W-1:0] next_q;
	logic [HI_Q_W-1:0] q100_q;

	logic [WR_W-1:0]     wr_ext;
	logic                wr_ok;
	logic [IDX_W-1:0]    wr_addr;
	logic [FREQ_W-1:0]   freq_rd;
	logic [DUR_W-1:0]    dur_rd;
	logic [TPM_W-1:0]    tpm_eff;
	logic [DUTY_W-1:0]   duty_eff;
	logic [QP_W-1:0]     q100_prod;
	logic [HP_W-1:0]     hi_prod;
	logic [LEFT_W-1:0]   left_prod;
	logic [PER_W-1:0]    phase_inc;
	logic                div_start;
	logic [PER_W-1:0]    div_dividend;
	logic [FREQ_W-1:0]   div_divisor;
	logic                div_busy;
	logic                div_done;
	logic [PER_W-1:0]    div_quo;
	logic [POS_W+IDX_W-1:0] pos_ext;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_HZ_RST;
			tpm_q      <= TPM_RST;
			duty_q     <= DUTY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLOCK_HZ:     clock_hz_q <= cfg_data[CLK_HZ_W-1:0];
				CFG_TICKS_PER_MS: tpm_q      <= cfg_data[TPM_W-1:0];
				CFG_DUTY_PERCENT: duty_q     <= cfg_data[DUTY_W-1:0];
				default:          ;
			endcase
		end
	end

	// note table
	assign wr_ext  = {{IDX_W{1'b0}}, entry_index};
	assign wr_ok   = wr_ext < WR_W'(TABLE_DEPTH);
	assign wr_addr = wr_ext[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr && !playing_q && wr_ok) begin
			mem[wr_addr] <= {entry_duration_ms, entry_freq_hz};
		end
		if (cmd.rd) begin
			rd_q <= mem[next_q[IDX_W-1:0]];
		end
	end

	assign freq_rd = rd_q[FREQ_W-1:0];
	assign dur_rd  = rd_q[MEM_W-1:FREQ_W];

	// period divide runs on the serial unit
	assign div_start    = cmd.div_per;
	assign div_dividend = clock_hz_q;
	assign div_divisor  = freq_rd;

	pst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// period / 100 by reciprocal multiply, registered before the duty scale
	assign q100_prod = QP_W'(period_q) * QP_W'(RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q100_q <= '0;
		end else if (cmd.div_hi) begin
			q100_q <= q100_prod[RECIP_SHIFT+HI_Q_W-1:RECIP_SHIFT];
		end
	end

	assign tpm_eff   = (tpm_q == '0) ? TPM_W'(1) : tpm_q;
	assign duty_eff  = (duty_q > DUTY_MAX) ? DUTY_MAX : duty_q;
	assign hi_prod   = HP_W'(q100_q) * HP_W'(duty_eff);
	assign left_prod = LEFT_W'(dur_rd) * LEFT_W'(tpm_eff);
	assign phase_inc = phase_q + PER_W'(1);

	// play state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			left_q    <= '0;
			period_q  <= '0;
			high_q    <= '0;
			phase_q   <= '0;
			cur_q     <= '0;
			next_q    <= '0;
		end else if (cmd.stop) begin
			playing_q <= 1'b0;
			left_q    <= '0;
			period_q  <= '0;
			high_q    <= '0;
			phase_q   <= '0;
			cur_q     <= '0;
		end else if (cmd.fin) begin
			high_q    <= hi_prod[PER_W-1:0];
			phase_q   <= '0;
			left_q    <= left_prod;
			cur_q     <= next_q[IDX_W-1:0];
			next_q    <= next_q + NEXT_W'(1);
			playing_q <= 1'b1;
		end else begin
			if (cmd.per_ld) begin
				period_q <= div_quo;
			end
			if (cmd.per_zero) begin
				period_q <= '0;
			end
			if (cmd.start) begin
				next_q <= '0;
			end
			if (cmd.tick && playing_q) begin
				if (period_q != '0) begin
					phase_q <= (phase_inc >= period_q) ? '0 : phase_inc;
				end
				if (left_q != '0) begin
					left_q <= left_q - LEFT_W'(1);
				end
			end
		end
	end

	assign sts.playing   = playing_q;
	assign sts.left_le1  = left_q <= LEFT_W'(1);
	assign sts.oob       = next_q >= NEXT_W'(TABLE_DEPTH);
	assign sts.dur_zero  = dur_rd == '0;
	assign sts.freq_zero = freq_rd == '0;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;

	assign pos_ext       = {{POS_W{1'b0}}, cur_q};
	assign tone_level    = playing_q && (period_q != '0) && (phase_q < high_q);
	assign busy_res      = playing_q;
	assign note_position = pos_ext[POS_W-1:0];

endmodule

// ===== hw/rtl/pst_ctrl.sv =====
// ----------------------------------------------------------------------------
// pst_ctrl
// control fsm: beat acceptance, note load sequence and result handshake
// ----------------------------------------------------------------------------
module pst_ctrl import pst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic [FUNC_W-1:0] func,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  pst_sts_t          sts,
	output pst_cmd_t          cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_CHK   = 3'd2;
	localparam logic [2:0] ST_DIV1  = 3'd3;
	localparam logic [2:0] ST_DIV2S = 3'd4;
	localparam logic [2:0] ST_DIV2  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       pend_q;
	logic       fin_item;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE) && (!pend_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = pend_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		fin_item  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FN_TICK: begin
							cmd.tick = 1'b1;
							if (sts.playing && sts.left_le1) begin
								state_nxt = ST_RD;
							end else begin
								fin_item = 1'b1;
							end
						end
						FN_START: begin
							cmd.start = 1'b1;
							if (!sts.playing) begin
								state_nxt = ST_RD;
							end else begin
								fin_item = 1'b1;
							end
						end
						FN_WRITE: begin
							cmd.wr   = 1'b1;
							fin_item = 1'b1;
						end
						default: fin_item = 1'b1;
					endcase
				end
			end
			ST_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = ST_CHK;
			end
			ST_CHK: begin
				if (sts.oob || sts.dur_zero) begin
					cmd.stop  = 1'b1;
					fin_item  = 1'b1;
					state_nxt = ST_IDLE;
				end else if (sts.freq_zero) begin
					cmd.per_zero = 1'b1;
					state_nxt    = ST_DIV2S;
				end else begin
					cmd.div_per = 1'b1;
					state_nxt   = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (sts.div_done) begin
					cmd.per_ld = 1'b1;
					state_nxt  = ST_DIV2S;
				end
			end
			ST_DIV2S: begin
				cmd.div_hi = 1'b1;
				state_nxt  = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.fin   = 1'b1;
				fin_item  = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fin_item) begin
				pend_q <= 1'b1;
			end else if (m_tready) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/pwm_tone_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// pwm_tone_sequencer_top
// plays a table of notes as a square wave, one result beat per input beat
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  tdata: entry fields, tuser: func
// m_*       out        m_tvalid/m_tready  tdata: level, busy, note position
// cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// write and start-while-playing beats, and tick beats that end no note, give their result the next cycle
// a beat that loads a note runs a table read, a check, a 26-step
// serial divide for the period, then a reciprocal multiply for the /100;
// a silent note skips the divide
// a beat that ends play stops after the table read and check; no clearing pass after reset
// a stalled m side holds its beat; s_tready drops until it drains
// config writes are taken in any cycle (cfg_ready is tied high)
//
`include "pwm_tone_sequencer_top_assert.svh"

module pwm_tone_sequencer_top import pst_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [4:0] entry_index, [20:5] entry_freq_hz, [28:21] entry_duration_ms, [31:29] zero
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// [1:0] func
	input  logic [FUNC_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] tone_level, [1] busy_res, [6:2] note_position, [7] zero
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pst_cmd_t          cmd;
	pst_sts_t          sts;
	logic              tone_level;
	logic              busy_res;
	logic [POS_W-1:0]  note_position;
	logic [IDX_IN_W-1:0] entry_index;
	logic [FREQ_W-1:0] entry_freq_hz;
	logic [DUR_W-1:0]  entry_duration_ms;

	// unpack the input beat
	assign entry_index       = s_tdata[IDX_IN_W-1:0];
	assign entry_freq_hz     = s_tdata[IDX_IN_W+FREQ_W-1:IDX_IN_W];
	assign entry_duration_ms = s_tdata[IDX_IN_W+FREQ_W+DUR_W-1:IDX_IN_W+FREQ_W];

	// config registers sit in the datapath and never back-pressure
	assign cfg_ready = 1'b1;

	pst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.func     (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pst_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.cmd               (cmd),
		.entry_index       (entry_index),
		.entry_freq_hz     (entry_freq_hz),
		.entry_duration_ms (entry_duration_ms),
		.sts               (sts),
		.tone_level        (tone_level),
		.busy_res          (busy_res),
		.note_position     (note_position)
	);

	// result beat reflects the play state, held until the next accepted beat
	assign m_tdata = {1'b0, note_position, busy_res, tone_level};

	// idle output is all quiet
	`PST_ASSERT_NOW(a_idle_quiet, m_tvalid && !m_tdata[1], m_tdata[0] == 1'b0 && m_tdata[6:2] == '0)
	// the divider is never mid-run while a beat can be accepted
	`PST_ASSERT_NOW(a_div_idle, s_tready, !sts.div_busy)
	// a table write never starts a note load, so its result is ready next cycle
	`PST_ASSERT_NEXT(a_write_1cyc, s_tvalid && s_tready && s_tuser == FN_WRITE, m_tvalid)

endmodule
